// ===== hdl/image_convolution_2d_core_defines.svh =====
// Assertion macros shared by the convolution core checkers.
// Each macro expects i_clk and i_rst_n in scope; no other dependencies.
`ifndef IMAGE_CONVOLUTION_2D_CORE_DEFINES_SVH
`define IMAGE_CONVOLUTION_2D_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IC2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IC2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ic2d_pkg.sv =====
// Types and constants of the 2D convolution core.
// No dependencies; imported by the core and its checker.
package ic2d_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 9;

    localparam int PIX_W   = 8;
    localparam int COEF_W  = 18;
    localparam int PROD_W  = PIX_W + 1 + COEF_W;
    localparam int ACC_W   = 32;
    localparam int POS_W   = 10;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_SIZE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_SIZE = 8'd1;

    localparam logic [8:0] IMAGE_SIZE_RST  = 9'd256;
    localparam logic [2:0] KERNEL_SIZE_RST = 3'd3;

    typedef enum logic [1:0] {
        REQ_COEF  = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_CONV  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_ROUND
    } t_state;

endpackage

// ===== hdl/ic2d_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ic2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/image_convolution_2d_core.sv =====
// Zero-padded square-image 2D convolution with a centered kernel. Items write
// a coefficient or a pixel (no result; the core stays ready) or request one
// output pixel, which keeps the core busy: the window of the effective kernel
// size is walked one tap per cycle, each tap one frame RAM read and one
// coefficient RAM read, then a multiply stage and accumulate, and last a
// rounding/clamp state. The finished pixel sits in an output register, so
// the next item is taken while it waits.
// Depends on ic2d_pkg and ic2d_ram.
module image_convolution_2d_core #(
    parameter int MAX_SIZE   = 256,
    parameter int MAX_KERNEL = 7,
    parameter int COEF_FRAC  = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ic2d_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ic2d_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row[7:0], col[15:8], pixel_value[23:16], coef_index[29:24], coef_value[47:30]
    input  logic [ic2d_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // req_type[1:0]
    input  logic [ic2d_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_pixel[7:0], out_row[15:8], out_col[23:16]
    output logic [ic2d_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import ic2d_pkg::*;

    localparam int FDEPTH = MAX_SIZE * MAX_SIZE;
    localparam int FAW    = $clog2(FDEPTH);
    localparam int CDEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int SZW    = ($clog2(MAX_SIZE + 1) > 9) ? $clog2(MAX_SIZE + 1) : 9;

    localparam logic [FAW-1:0] MS_F    = FAW'(MAX_SIZE);
    localparam logic [SZW-1:0] MS_S    = SZW'(MAX_SIZE);
    localparam logic [3:0]     MK      = 4'(MAX_KERNEL);
    localparam logic [7:0]     NCOEF   = 8'(CDEPTH);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (COEF_FRAC - 1));

    // config registers
    logic [8:0] r_image_size;
    logic [2:0] r_kernel_size;

    // control
    t_state r_state, n_state;
    logic   r_s1_vld, r_s1_inb, r_s2_vld, r_out_vld, n_out_vld;

    // payload
    logic [7:0]              r_row, r_col, r_out_pix, r_out_row, r_out_col;
    logic [2:0]              r_fi, r_fj;
    logic [5:0]              r_ci;
    logic signed [POS_W-1:0] r_ir, r_ic;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // input fields
    t_req                req_type;
    logic [7:0]          in_row, in_col, in_pix;
    logic [5:0]          in_cidx;
    logic [COEF_W-1:0]   in_coef;

    assign req_type = t_req'(s_axis_tuser);
    assign in_row   = s_axis_tdata[7:0];
    assign in_col   = s_axis_tdata[15:8];
    assign in_pix   = s_axis_tdata[23:16];
    assign in_cidx  = s_axis_tdata[29:24];
    assign in_coef  = s_axis_tdata[47:30];

    // effective sizes
    logic [8:0]  m_eff;
    logic [2:0]  k_eff;
    logic [1:0]  pad;

    always_comb begin
        if (r_image_size == 9'd0) begin
            m_eff = 9'd1;
        end else if (SZW'(r_image_size) > MS_S) begin
            m_eff = 9'(MAX_SIZE);
        end else begin
            m_eff = r_image_size;
        end
        if (r_kernel_size == 3'd0) begin
            k_eff = 3'd1;
        end else if ({1'b0, r_kernel_size} > MK) begin
            k_eff = MK[2:0];
        end else begin
            k_eff = r_kernel_size;
        end
        pad = k_eff[2:1];
    end

    logic in_acc, frame_we, coef_we, start;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign start    = in_acc && (req_type == REQ_CONV);
    assign coef_we  = in_acc && (req_type == REQ_COEF) && ({2'b00, in_cidx} < NCOEF);
    assign frame_we = in_acc && (req_type == REQ_PIXEL) &&
                      ({1'b0, in_row} < m_eff) && ({1'b0, in_col} < m_eff);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size  <= IMAGE_SIZE_RST;
            r_kernel_size <= KERNEL_SIZE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_SIZE:  r_image_size  <= i_cfg_data;
                CFG_KERNEL_SIZE: r_kernel_size <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // window tap address and bounds
    logic [FAW-1:0] frame_waddr, frame_raddr;
    logic           tap_inb, last_col, last_tap;

    assign frame_waddr = FAW'(FAW'(in_row) * MS_F + FAW'(in_col));
    assign frame_raddr = FAW'(FAW'(r_ir[8:0]) * MS_F + FAW'(r_ic[8:0]));
    assign tap_inb  = !r_ir[POS_W-1] && (r_ir[8:0] < m_eff) &&
                      !r_ic[POS_W-1] && (r_ic[8:0] < m_eff);
    assign last_col = (r_fj == k_eff - 3'd1);
    assign last_tap = last_col && (r_fi == k_eff - 3'd1);

    logic [PIX_W-1:0]  pix_rd;
    logic [COEF_W-1:0] coef_rd;

    ic2d_ram #(.WIDTH(PIX_W), .DEPTH(FDEPTH)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_waddr (frame_waddr),
        .i_wdata (in_pix),
        .i_raddr (frame_raddr),
        .o_rdata (pix_rd)
    );

    ic2d_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (CAW'(in_cidx)),
        .i_wdata (in_coef),
        .i_raddr (CAW'(r_ci)),
        .o_rdata (coef_rd)
    );

    // round and clamp
    logic signed [ACC_W-1:0] rnd, q;
    logic [PIX_W-1:0]        res_pix;
    logic                    load_out;

    always_comb begin
        rnd = r_acc + RND_HALF;
        q   = rnd >>> COEF_FRAC;
        if (rnd[ACC_W-1]) begin
            res_pix = '0;
        end else if (q > ACC_W'(PIX_MAX)) begin
            res_pix = PIX_MAX;
        end else begin
            res_pix = q[PIX_W-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (last_tap) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (!r_out_vld || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s1_vld  <= (r_state == ST_RUN);
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_inb <= tap_inb;
        if (r_s1_inb) begin
            r_prod <= $signed({1'b0, pix_rd}) * $signed(coef_rd);
        end else begin
            r_prod <= '0;
        end
        if (start) begin
            r_row <= in_row;
            r_col <= in_col;
            r_fi  <= '0;
            r_fj  <= '0;
            r_ci  <= '0;
            r_ir  <= POS_W'({2'b00, in_row}) - POS_W'(pad);
            r_ic  <= POS_W'({2'b00, in_col}) - POS_W'(pad);
            r_acc <= '0;
        end else begin
            if (r_state == ST_RUN) begin
                r_ci <= r_ci + 6'd1;
                if (last_col) begin
                    r_fj <= '0;
                    r_fi <= r_fi + 3'd1;
                    r_ir <= r_ir + POS_W'(1);
                    r_ic <= POS_W'({2'b00, r_col}) - POS_W'(pad);
                end else begin
                    r_fj <= r_fj + 3'd1;
                    r_ic <= r_ic + POS_W'(1);
                end
            end
            if (r_s2_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (load_out) begin
            r_out_pix <= res_pix;
            r_out_row <= r_row;
            r_out_col <= r_col;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_col, r_out_row, r_out_pix};

endmodule

// ===== hdl/ic2d_checker.sv =====
// Port-level checker for the convolution core, bound to the core module.
// Depends on ic2d_pkg and image_convolution_2d_core_defines.svh.
`include "image_convolution_2d_core_defines.svh"

module ic2d_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [ic2d_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ic2d_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import ic2d_pkg::*;

    logic req_acc, wr_acc;
    assign req_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_CONV);
    assign wr_acc  = s_axis_tvalid && s_axis_tready &&
                     ((s_axis_tuser == REQ_COEF) || (s_axis_tuser == REQ_PIXEL));

    `IC2D_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result item changed")
    `IC2D_ASSERT_NEXT(a_req_busy, req_acc, !s_axis_tready,
        "core still ready after taking a request")
    `IC2D_ASSERT_NOW(a_out_after_busy, $rose(m_axis_tvalid), $past(!s_axis_tready),
        "result item appeared without a request in progress")
    `IC2D_ASSERT_NEXT(a_write_silent, wr_acc && !m_axis_tvalid, !m_axis_tvalid,
        "write item produced a result item")

endmodule

bind image_convolution_2d_core ic2d_checker u_ic2d_checker (.*);
